### rtl/lec_residue_vlc_decoder_unit_macros.svh
// Assertion helpers for the checker of this block.
// A checker that uses them must have clk and arst_n in scope.
`ifndef LEC_RESIDUE_VLC_DECODER_UNIT_MACROS_SVH
`define LEC_RESIDUE_VLC_DECODER_UNIT_MACROS_SVH

`define LRVD_ASSERT(label, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);

`define LRVD_ASSERT_NEXT(label, ante, cons, msg) \
	`LRVD_ASSERT(label, (ante) |=> (cons), msg)

`endif

### rtl/lrvd_pkg.sv
package lrvd_pkg;

	localparam int VALUE_W    = 15;
	localparam int BUF_W      = 24;
	localparam int CNT_W      = 5;
	localparam int CAT_W      = 4;
	localparam int LEN_W      = 4;
	localparam int AMP_W      = 14;
	localparam int PREFIX_MAX = 12;
	localparam int MAX_CATS   = 15;
	localparam int MAX_RES    = 4;
	localparam int RES_W      = 3;

	// The most negative 15-bit code never shows up as a decoded value.
	localparam logic [VALUE_W-1:0] ILLEGAL_VALUE = 15'h4000;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_RUN,
		ST_FLUSH
	} state_t;

	// What the shared decode unit reports about the head of the bit buffer.
	typedef struct packed {
		logic               hit;
		logic [CAT_W-1:0]   cat;
		logic [LEN_W-1:0]   len;
		logic               amp_ok;
		logic [VALUE_W-1:0] amp_value;
	} step_t;

	function automatic logic [LEN_W-1:0] code_len(input logic [CAT_W-1:0] n);
		logic [LEN_W-1:0] r;
		if (n == '0) begin
			r = 4'd2;
		end else if (n <= 4'd5) begin
			r = 4'd3;
		end else begin
			r = n - 4'd2;
		end
		return r;
	endfunction

	function automatic logic [PREFIX_MAX-1:0] code_bits(input logic [CAT_W-1:0] n);
		logic [PREFIX_MAX-1:0] r;
		if (n == '0) begin
			r = '0;
		end else if (n <= 4'd5) begin
			r = PREFIX_MAX'(n) + 12'd1;
		end else begin
			// Run of ones closed by a zero.
			r = (12'd1 << (n - 4'd2)) - 12'd2;
		end
		return r;
	endfunction

endpackage

### rtl/lrvd_in_if.sv
interface lrvd_in_if;
	logic       valid;
	logic       ready;
	logic [7:0] data_byte;
	logic       last_byte;

	modport source (output valid, output data_byte, output last_byte, input ready);
	modport sink (input valid, input data_byte, input last_byte, output ready);
endinterface

### rtl/lrvd_out_if.sv
interface lrvd_out_if;
	logic               valid;
	logic               ready;
	logic signed [14:0] value;
	logic               is_error;
	logic               last;

	modport source (output valid, output value, output is_error, output last, input ready);
	modport sink (input valid, input value, input is_error, input last, output ready);
endinterface

### rtl/lrvd_step.sv
module lrvd_step import lrvd_pkg::*; #(
	parameter int NUM_CATEGORIES = 15
) (
	input  logic [BUF_W-1:0] bits,
	input  logic [CNT_W-1:0] cnt,
	input  logic [CAT_W-1:0] pcat,
	output step_t            step
);

	logic [BUF_W-1:0]      aligned;
	logic [PREFIX_MAX-1:0] win;
	logic [AMP_W-1:0]      ai;
	logic [15:0]           ai_x;
	logic [VALUE_W-1:0]    mag;
	logic [CAT_W-1:0]      sign_idx;

	// Left-align the valid bits so the next field always starts at the top.
	assign aligned = bits << (CNT_W'(BUF_W) - cnt);
	assign win     = aligned[BUF_W-1 -: PREFIX_MAX];

	assign ai       = aligned[BUF_W-1 -: AMP_W] >> (LEN_W'(AMP_W) - pcat);
	assign ai_x     = {2'b00, ai};
	assign sign_idx = pcat - 4'd1;
	assign mag      = (15'd1 << pcat) - 15'd1;

	always_comb begin
		step.hit = 1'b0;
		step.cat = '0;
		// Scan downward so the lowest matching category wins.
		for (int n = MAX_CATS - 1; n >= 0; n--) begin
			if (n < NUM_CATEGORIES) begin
				if (cnt >= CNT_W'(code_len(CAT_W'(n))) &&
				    (win >> (LEN_W'(PREFIX_MAX) - code_len(CAT_W'(n)))) ==
				    code_bits(CAT_W'(n))) begin
					step.hit = 1'b1;
					step.cat = CAT_W'(n);
				end
			end
		end
		step.len = code_len(step.cat);
		step.amp_ok = cnt >= CNT_W'(pcat);
		if (ai_x[sign_idx]) begin
			step.amp_value = {1'b0, ai};
		end else begin
			step.amp_value = {1'b0, ai} - mag;
		end
	end

endmodule

### rtl/lec_residue_vlc_decoder_unit.sv
// Residue VLC decoder. Bytes enter most significant bit first; each residue is a
// prefix codeword for a category n followed by n amplitude bits, and comes out as a
// 15-bit two's complement value. A 12-bit prefix that matches no codeword gives one
// error result (value 0), after which bytes are dropped until the byte flagged
// last_byte, which also ends the stream and clears all decoder state. The result
// marked last is the final one caused by that byte; if it causes none, no result
// carries last. A byte is loaded, then each codeword prefix and each amplitude field is
// decoded in turn (at most four results per byte), then the unit finds that nothing
// more decodes and closes out; a new byte is taken only after that. The pace is set
// by the single shared decode unit, which handles one field of the bit buffer per
// cycle unless the result side holds off ready.
module lec_residue_vlc_decoder_unit import lrvd_pkg::*; #(
	parameter int NUM_CATEGORIES = 15
) (
	input  logic       clk,
	input  logic       arst_n,
	lrvd_in_if.sink    bytes,
	lrvd_out_if.source results
);

	state_t             state_q, state_d;
	logic [BUF_W-1:0]   buf_q;
	logic [CNT_W-1:0]   cnt_q;
	logic [CAT_W-1:0]   pcat_q;
	logic               await_q;
	logic               err_q;
	logic [RES_W-1:0]   k_q;
	logic               last_q;
	logic               pend_v_q;
	logic [VALUE_W-1:0] pend_val_q;
	logic               pend_err_q;
	logic               ov_q;
	logic [VALUE_W-1:0] o_val_q;
	logic               o_err_q;
	logic               o_last_q;

	step_t st;
	logic  accept, out_free, done, produce, advance, push, flush_go;

	lrvd_step #(.NUM_CATEGORIES(NUM_CATEGORIES)) u_step (
		.bits(buf_q),
		.cnt (cnt_q),
		.pcat(pcat_q),
		.step(st)
	);

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (bytes.valid) begin
					state_d = ST_RUN;
				end
			end
			ST_RUN: begin
				if (done) begin
					state_d = ST_FLUSH;
				end
			end
			ST_FLUSH: begin
				if (flush_go) begin
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_comb begin
		bytes.ready = (state_q == ST_IDLE);
		accept      = bytes.valid && bytes.ready;
		out_free    = !ov_q || results.ready;
		done = err_q || (k_q == RES_W'(MAX_RES)) ||
		       (await_q ? !st.amp_ok : (!st.hit && cnt_q < CNT_W'(PREFIX_MAX)));
		// Category zero, an amplitude and a bad prefix each yield a result.
		produce  = !done && (await_q || !st.hit || st.cat == '0);
		advance  = (state_q == ST_RUN) && !done && !(produce && pend_v_q && !out_free);
		flush_go = (state_q == ST_FLUSH) && (!pend_v_q || out_free);
		push     = (advance && produce && pend_v_q) || (flush_go && pend_v_q);
	end

	assign results.valid    = ov_q;
	assign results.value    = o_val_q;
	assign results.is_error = o_err_q;
	assign results.last     = o_last_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= ST_IDLE;
			cnt_q    <= '0;
			pcat_q   <= '0;
			await_q  <= 1'b0;
			err_q    <= 1'b0;
			k_q      <= '0;
			last_q   <= 1'b0;
			pend_v_q <= 1'b0;
			ov_q     <= 1'b0;
		end else begin
			state_q <= state_d;
			if (accept) begin
				if (!err_q) begin
					cnt_q <= cnt_q + 5'd8;
				end
				k_q    <= '0;
				last_q <= bytes.last_byte;
			end
			if (advance) begin
				if (await_q) begin
					cnt_q   <= cnt_q - CNT_W'(pcat_q);
					await_q <= 1'b0;
					pcat_q  <= '0;
				end else if (st.hit) begin
					cnt_q <= cnt_q - CNT_W'(st.len);
					if (st.cat != '0) begin
						pcat_q  <= st.cat;
						await_q <= 1'b1;
					end
				end else begin
					cnt_q <= '0;
					err_q <= 1'b1;
				end
				if (produce) begin
					k_q      <= k_q + 3'd1;
					pend_v_q <= 1'b1;
				end
			end
			if (flush_go) begin
				pend_v_q <= 1'b0;
				if (last_q) begin
					cnt_q   <= '0;
					pcat_q  <= '0;
					await_q <= 1'b0;
					err_q   <= 1'b0;
				end
			end
			if (push) begin
				ov_q <= 1'b1;
			end else if (results.ready) begin
				ov_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept && !err_q) begin
			buf_q <= {buf_q[BUF_W-9:0], bytes.data_byte};
		end
		if (advance && produce) begin
			pend_val_q <= await_q ? st.amp_value : '0;
			pend_err_q <= !await_q && !st.hit;
		end
		if (push) begin
			o_val_q  <= pend_val_q;
			o_err_q  <= pend_err_q;
			o_last_q <= flush_go && last_q;
		end
	end

endmodule

### rtl/lrvd_checker.sv
`include "lec_residue_vlc_decoder_unit_macros.svh"

module lrvd_checker import lrvd_pkg::*; (
	input logic               clk,
	input logic               arst_n,
	input logic               in_valid,
	input logic               in_ready,
	input logic               out_valid,
	input logic               out_ready,
	input logic [VALUE_W-1:0] out_value,
	input logic               out_is_error
);

	// A byte is decoded before the next is taken, so the input closes right after a beat.
	`LRVD_ASSERT_NEXT(a_busy_after_beat, in_valid && in_ready, !in_ready, "ready stayed high after an input beat")

	`LRVD_ASSERT(a_error_value_zero, out_valid && out_is_error |-> out_value == '0, "error result with nonzero value")

	`LRVD_ASSERT(a_value_in_range, out_valid |-> out_value != ILLEGAL_VALUE, "decoded value out of range")

	`LRVD_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(out_value), "stalled result changed")

endmodule

bind lec_residue_vlc_decoder_unit lrvd_checker u_lrvd_checker (
	.clk         (clk),
	.arst_n      (arst_n),
	.in_valid    (bytes.valid),
	.in_ready    (bytes.ready),
	.out_valid   (results.valid),
	.out_ready   (results.ready),
	.out_value   (results.value),
	.out_is_error(results.is_error)
);

### tb/sv/residue_check_pkg.sv
`timescale 1ns / 100ps

package residue_check_pkg;
	import lrvd_pkg::*;

	typedef struct packed {
		logic [VALUE_W-1:0] value;
		logic               is_error;
		logic               last;
	} residue_t;

	class residue_scoreboard;
		logic [31:0] window;
		int unsigned fill;
		int unsigned amp_cat;
		bit          amp_due;
		bit          dropping;
		residue_t    expected_residues[$];
		int unsigned failures;

		function new();
			clear_stream();
			failures = 0;
		endfunction

		function void clear_stream();
			window = '0;
			fill = 0;
			amp_cat = 0;
			amp_due = 0;
			dropping = 0;
		endfunction

		function logic [31:0] peek(int unsigned len);
			return (window >> (fill - len)) & ((32'd1 << len) - 1);
		endfunction

		function logic [31:0] pull(int unsigned len);
			logic [31:0] r;
			r = peek(len);
			fill -= len;
			window &= (32'd1 << fill) - 1;
			return r;
		endfunction

		// Runs the decoder over one accepted byte and queues the residues it yields.
		function void note_byte(logic [7:0] data, logic fin);
			residue_t    batch[$];
			residue_t    r;
			int unsigned ones;
			logic [31:0] ai;
			bit          stalled;
			stalled = 0;
			if (!dropping) begin
				window = ((window << 8) | 32'(data)) & 32'h00FF_FFFF;
				fill += 8;
			end
			while (!dropping && !stalled && batch.size() < MAX_RES) begin
				r = '0;
				if (amp_due) begin
					if (fill < amp_cat) begin
						stalled = 1;
					end else begin
						ai = pull(amp_cat);
						// The lower half of the amplitude range maps onto negative values.
						if (ai < (32'd1 << (amp_cat - 1))) begin
							r.value = VALUE_W'(ai - ((32'd1 << amp_cat) - 1));
						end else begin
							r.value = VALUE_W'(ai);
						end
						batch.push_back(r);
						amp_due = 0;
						amp_cat = 0;
					end
				end else begin
					ones = 0;
					while (ones < fill && ones < PREFIX_MAX && window[fill - 1 - ones]) begin
						ones++;
					end
					if (ones == PREFIX_MAX) begin
						r.is_error = 1'b1;
						batch.push_back(r);
						window = '0;
						fill = 0;
						dropping = 1;
					end else if (ones == fill) begin
						stalled = 1;
					end else if (ones >= 3) begin
						// A run of ones closed by a zero selects the long categories.
						void'(pull(ones + 1));
						amp_cat = ones + 3;
						amp_due = 1;
					end else if (fill >= 2 && peek(2) == 0) begin
						void'(pull(2));
						batch.push_back(r);
					end else if (fill < 3) begin
						stalled = 1;
					end else begin
						amp_cat = pull(3) - 1;
						amp_due = 1;
					end
				end
			end
			if (fin) begin
				if (batch.size() > 0) begin
					batch[batch.size() - 1].last = 1'b1;
				end
				clear_stream();
			end
			foreach (batch[i]) begin
				expected_residues.push_back(batch[i]);
			end
		endfunction

		function void check_result(residue_t got);
			residue_t want;
			if (expected_residues.size() == 0) begin
				$error("result beat with no residue pending: value %0d is_error %0b last %0b",
					$signed(got.value), got.is_error, got.last);
				failures++;
				return;
			end
			want = expected_residues.pop_front();
			if (got.value !== want.value) begin
				$error("value: expected %0d, actual %0d", $signed(want.value), $signed(got.value));
				failures++;
			end
			if (got.is_error !== want.is_error) begin
				$error("is_error: expected %0b, actual %0b", want.is_error, got.is_error);
				failures++;
			end
			if (got.last !== want.last) begin
				$error("last: expected %0b, actual %0b", want.last, got.last);
				failures++;
			end
		endfunction

		function int unsigned outstanding();
			return expected_residues.size();
		endfunction
	endclass

endpackage

### tb/sv/testbench.sv
`timescale 1ns / 100ps

module testbench;
	import lrvd_pkg::*;
	import residue_check_pkg::*;

	logic clk;
	logic arst_n;

	lrvd_in_if  byte_ch();
	lrvd_out_if result_ch();

	lec_residue_vlc_decoder_unit dut (
		.clk     (clk),
		.arst_n  (arst_n),
		.bytes   (byte_ch),
		.results (result_ch)
	);

	residue_scoreboard sb;

	bit stream_bits[$];
	int err_bit;
	int fed;
	int send_idle;
	int take_idle;

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	initial begin
		#2_000_000;
		$display("[FAIL] regression broken");
		$finish;
	end

	always @(negedge clk) begin
		result_ch.ready = ($urandom_range(0, 99) >= take_idle);
	end

	always @(posedge clk) begin
		residue_t got;
		if (arst_n) begin
			if (byte_ch.valid && byte_ch.ready) begin
				sb.note_byte(byte_ch.data_byte, byte_ch.last_byte);
			end
			if (result_ch.valid && result_ch.ready) begin
				got.value = result_ch.value;
				got.is_error = result_ch.is_error;
				got.last = result_ch.last;
				sb.check_result(got);
			end
		end
	end

	function automatic void push_bit(int unsigned b);
		stream_bits.push_back(1'(b));
	endfunction

	// Appends the prefix codeword of category n and its n amplitude bits.
	function automatic void push_code(int unsigned n, int unsigned amp);
		if (n == 0) begin
			push_bit(0);
			push_bit(0);
		end else if (n <= 5) begin
			for (int i = 2; i >= 0; i--) push_bit(((n + 1) >> i) & 1);
		end else begin
			repeat (n - 3) push_bit(1);
			push_bit(0);
		end
		for (int i = int'(n) - 1; i >= 0; i--) push_bit((amp >> i) & 1);
	endfunction

	function automatic void push_residue();
		int unsigned w;
		int unsigned n;
		int unsigned amp;
		w = $urandom_range(0, 99);
		if (w < 50) begin
			n = $urandom_range(0, 5);
		end else if (w < 85) begin
			n = $urandom_range(6, 10);
		end else begin
			n = $urandom_range(11, 14);
		end
		case ($urandom_range(0, 7))
			0: amp = 0;
			1: amp = (1 << n) - 1;
			default: amp = $urandom() & ((1 << n) - 1);
		endcase
		push_code(n, amp);
	endfunction

	task automatic send_byte(input logic [7:0] data, input logic fin);
		while ($urandom_range(0, 99) < send_idle) begin
			byte_ch.valid = 1'b0;
			@(negedge clk);
		end
		byte_ch.valid = 1'b1;
		byte_ch.data_byte = data;
		byte_ch.last_byte = fin;
		@(posedge clk);
		while (!byte_ch.ready) @(posedge clk);
		@(negedge clk);
	endtask

	// Pads the pending bits to whole bytes and sends them as one stream.
	task automatic emit_stream();
		int nbytes;
		logic [7:0] b;
		while (stream_bits.size() % 8 != 0) push_bit($urandom_range(0, 1));
		nbytes = stream_bits.size() / 8;
		for (int i = 0; i < nbytes; i++) begin
			for (int j = 0; j < 8; j++) b[7 - j] = stream_bits[8 * i + j];
			if (err_bit < 0 || 8 * i < err_bit) fed++;
			send_byte(b, i == nbytes - 1);
		end
		stream_bits.delete();
		err_bit = -1;
	endtask

	task automatic directed_checks();
		// Every category once, odd ones with full amplitude and even ones with zero.
		for (int n = 0; n < MAX_CATS; n++) push_code(n, (n % 2) ? ((1 << n) - 1) : 0);
		emit_stream();
		send_byte(8'h00, 1'b1);
		// An invalid prefix, then a final byte that yields nothing.
		send_byte(8'hFF, 1'b0);
		send_byte(8'hFF, 1'b0);
		send_byte(8'h3C, 1'b1);
		fed += 4;
	endtask

	task automatic random_stream();
		int kind;
		int cut;
		kind = $urandom_range(0, 99);
		if (kind < 8) begin
			repeat ($urandom_range(1, 6) * 8) push_bit($urandom_range(0, 1));
		end else begin
			repeat ($urandom_range(1, 10)) push_residue();
			if (kind < 20) begin
				repeat (PREFIX_MAX) push_bit(1);
				err_bit = stream_bits.size();
				repeat ($urandom_range(0, 20)) push_bit($urandom_range(0, 1));
			end else if (kind < 30) begin
				// Cut the stream short so the last codeword or amplitude may be left unfinished.
				cut = $urandom_range(1, 10);
				while (cut > 0 && stream_bits.size() > 1) begin
					void'(stream_bits.pop_back());
					cut--;
				end
			end
		end
		emit_stream();
	endtask

	initial begin
		int base;
		arst_n = 1'b0;
		byte_ch.valid = 1'b0;
		byte_ch.data_byte = '0;
		byte_ch.last_byte = 1'b0;
		send_idle = 0;
		take_idle = 0;
		err_bit = -1;
		fed = 0;
		sb = new();
		repeat (12) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);
		directed_checks();
		base = fed;
		for (int ph = 0; ph < 3; ph++) begin
			send_idle = (ph == 0) ? 18 : (ph == 1) ? 61 : 0;
			take_idle = (ph == 0) ? 61 : (ph == 1) ? 18 : 0;
			while (fed < base + 120 * (ph + 1)) random_stream();
		end
		byte_ch.valid = 1'b0;
		while (sb.outstanding() != 0) @(posedge clk);
		repeat (48) @(posedge clk);
		if (sb.failures == 0 && sb.outstanding() == 0) begin
			$display("[ OK ] regression clean");
		end else begin
			$display("[FAIL] regression broken");
		end
		$finish;
	end

endmodule

### files.f
+incdir+rtl
rtl/lrvd_pkg.sv
rtl/lrvd_in_if.sv
rtl/lrvd_out_if.sv
rtl/lrvd_step.sv
rtl/lec_residue_vlc_decoder_unit.sv
rtl/lrvd_checker.sv
tb/sv/residue_check_pkg.sv
tb/sv/testbench.sv
